/* hdl/dlcar_pkg.sv */
package dlcar_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_HALF_PERIOD  = 2'd0;
    localparam logic [1:0] REG_TARE_SAMPLES = 2'd1;
    localparam logic [1:0] REG_TARE_TIMEOUT = 2'd2;

    localparam logic [9:0]  HALF_PERIOD_RST  = 10'd100;
    localparam logic [7:0]  TARE_SAMPLES_RST = 8'd10;
    localparam logic [15:0] TARE_TIMEOUT_RST = 16'd2000;

    localparam int unsigned IN_W   = 8;
    localparam int unsigned OUT_W  = 104;
    localparam int unsigned READ_W = 24;

    typedef struct packed {
        logic [9:0]  half_period;
        logic [7:0]  tare_samples;
        logic [15:0] tare_timeout;
    } t_cfg;

    typedef struct packed {
        logic shift_clr;
        logic shift_en;
        logic held_load;
        logic tare_clr;
        logic tare_acc;
    } t_dp_cmd;

endpackage

/* hdl/dlcar_div.sv */
module dlcar_div #(
    parameter int SUM_W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend_a,
    input  logic signed [SUM_W-1:0] i_dividend_b,
    input  logic [7:0]              i_divisor,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quot_a,
    output logic signed [SUM_W-1:0] o_quot_b
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_div;
    logic [SUM_W-1:0] r_q   [2];
    logic [7:0]       r_rem [2];
    logic             r_neg [2];

    logic signed [SUM_W-1:0] dvd    [2];
    logic [SUM_W-1:0]        mag    [2];
    logic [8:0]              rem_sh [2];
    logic                    ge     [2];
    logic [7:0]              n_rem  [2];
    logic [SUM_W-1:0]        n_q    [2];

    assign dvd[0] = i_dividend_a;
    assign dvd[1] = i_dividend_b;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag[l]    = dvd[l][SUM_W-1] ? SUM_W'(-dvd[l]) : SUM_W'(dvd[l]);
            rem_sh[l] = {r_rem[l], r_q[l][SUM_W-1]};
            ge[l]     = rem_sh[l] >= {1'b0, r_div};
            n_rem[l]  = ge[l] ? 8'(rem_sh[l] - {1'b0, r_div}) : rem_sh[l][7:0];
            n_q[l]    = {r_q[l][SUM_W-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            for (int l = 0; l < 2; l++) begin
                r_q[l]   <= mag[l];
                r_rem[l] <= '0;
                r_neg[l] <= dvd[l][SUM_W-1];
            end
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_q[l]   <= n_q[l];
                r_rem[l] <= n_rem[l];
            end
        end
    end

    assign o_done   = r_done;
    assign o_quot_a = r_neg[0] ? -$signed(r_q[0]) : $signed(r_q[0]);
    assign o_quot_b = r_neg[1] ? -$signed(r_q[1]) : $signed(r_q[1]);

endmodule

/* hdl/dlcar_dp.sv */
module dlcar_dp #(
    parameter int DATA_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlcar_pkg::t_dp_cmd            i_cmd,
    input  logic                          i_data_a,
    input  logic                          i_data_b,
    input  logic                          i_div_done,
    input  logic signed [DATA_BITS+7:0]   i_quot_a,
    input  logic signed [DATA_BITS+7:0]   i_quot_b,
    output logic signed [DATA_BITS+7:0]   o_sum_next_a,
    output logic signed [DATA_BITS+7:0]   o_sum_next_b,
    output logic signed [23:0]            o_reading_a,
    output logic signed [23:0]            o_reading_b,
    output logic signed [23:0]            o_tare_value_a,
    output logic signed [23:0]            o_tare_value_b
);

    localparam int SUM_W = DATA_BITS + 8;

    function automatic logic signed [23:0] sat24(input logic signed [SUM_W-1:0] v);
        logic signed [40:0] w;
        logic signed [23:0] r;
        w = 41'(v);
        if (w > 41'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (w < -41'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = w[23:0];
        end
        return r;
    endfunction

    logic [DATA_BITS-1:0]    r_shift_a, r_shift_b;
    logic [DATA_BITS-1:0]    r_held_a, r_held_b;
    logic signed [SUM_W-1:0] r_sum_a, r_sum_b;
    logic signed [23:0]      r_tare_a, r_tare_b;
    logic signed [SUM_W-1:0] word_a, word_b;
    logic signed [SUM_W-1:0] held_x_a, held_x_b;

    assign word_a = SUM_W'($signed(r_shift_a));
    assign word_b = SUM_W'($signed(r_shift_b));

    assign o_sum_next_a = (i_cmd.tare_clr ? '0 : r_sum_a) + (i_cmd.tare_acc ? word_a : '0);
    assign o_sum_next_b = (i_cmd.tare_clr ? '0 : r_sum_b) + (i_cmd.tare_acc ? word_b : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_clr) begin
            r_shift_a <= '0;
            r_shift_b <= '0;
        end else if (i_cmd.shift_en) begin
            r_shift_a <= {r_shift_a[DATA_BITS-2:0], i_data_a};
            r_shift_b <= {r_shift_b[DATA_BITS-2:0], i_data_b};
        end
        if (i_cmd.tare_clr || i_cmd.tare_acc) begin
            r_sum_a <= o_sum_next_a;
            r_sum_b <= o_sum_next_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_a <= '0;
            r_held_b <= '0;
            r_tare_a <= '0;
            r_tare_b <= '0;
        end else begin
            if (i_cmd.held_load) begin
                r_held_a <= r_shift_a;
                r_held_b <= r_shift_b;
            end
            if (i_div_done) begin
                r_tare_a <= sat24(i_quot_a);
                r_tare_b <= sat24(i_quot_b);
            end
        end
    end

    assign held_x_a       = SUM_W'($signed(r_held_a));
    assign held_x_b       = SUM_W'($signed(r_held_b));
    assign o_reading_a    = sat24(held_x_a);
    assign o_reading_b    = sat24(held_x_b);
    assign o_tare_value_a = r_tare_a;
    assign o_tare_value_b = r_tare_b;

endmodule

/* hdl/dlcar_ctrl.sv */
module dlcar_ctrl #(
    parameter int DATA_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dlcar_pkg::t_cfg    i_cfg,
    input  logic               i_s_valid,
    input  logic               i_data_a,
    input  logic               i_data_b,
    input  logic               i_ms,
    input  logic               i_req,
    output logic               o_s_ready,
    input  logic               i_m_ready,
    output logic               o_m_valid,
    output logic               o_serial_clock,
    output logic               o_reading_valid,
    output logic               o_tare_done,
    output logic               o_tare_failed,
    output dlcar_pkg::t_dp_cmd o_cmd,
    output logic               o_div_start,
    output logic [7:0]         o_div_count,
    input  logic               i_div_done
);

    localparam int PC_W = $clog2(DATA_BITS + 2);

    dlcar_pkg::t_phase r_phase, n_phase;
    logic [PC_W-1:0]   r_pulse, n_pulse, pulse_inc;
    logic [9:0]        r_half, n_half, hp;
    logic [10:0]       half_inc;
    logic              half_end;
    logic              rd_valid, shift_en, shift_clr;

    logic              r_active, n_active, active_eff, start_run, acc;
    logic [7:0]        r_got, n_got, got_eff;
    logic [15:0]       r_el, n_el, el_eff;
    logic              run_end, run_fail, div_go;

    logic              r_out_full, r_div_busy;
    logic              r_f_valid, r_f_done, r_f_failed;
    logic              accept, out_take;

    assign out_take  = o_m_valid && i_m_ready;
    assign o_m_valid = r_out_full && !r_div_busy;
    assign o_s_ready = !r_div_busy && (!r_out_full || out_take);
    assign accept    = i_s_valid && o_s_ready;

    assign hp        = (i_cfg.half_period == '0) ? 10'd1 : i_cfg.half_period;
    assign half_inc  = {1'b0, r_half} + 11'd1;
    assign half_end  = half_inc >= {1'b0, hp};
    assign pulse_inc = r_pulse + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_pulse   = r_pulse;
        n_half    = r_half;
        rd_valid  = 1'b0;
        shift_en  = 1'b0;
        shift_clr = 1'b0;
        case (r_phase)
            dlcar_pkg::PH_IDLE: begin
                if (!i_data_a && !i_data_b) begin
                    n_phase   = dlcar_pkg::PH_HIGH;
                    n_pulse   = '0;
                    n_half    = '0;
                    shift_clr = 1'b1;
                end
            end
            dlcar_pkg::PH_HIGH: begin
                if (half_end) begin
                    shift_en = r_pulse < PC_W'(DATA_BITS);
                    n_phase  = dlcar_pkg::PH_LOW;
                    n_half   = '0;
                end else begin
                    n_half = half_inc[9:0];
                end
            end
            dlcar_pkg::PH_LOW: begin
                if (half_end) begin
                    n_half = '0;
                    if (pulse_inc >= PC_W'(DATA_BITS + 1)) begin
                        rd_valid = 1'b1;
                        n_phase  = dlcar_pkg::PH_IDLE;
                        n_pulse  = '0;
                    end else begin
                        n_pulse = pulse_inc;
                        n_phase = dlcar_pkg::PH_HIGH;
                    end
                end else begin
                    n_half = half_inc[9:0];
                end
            end
            default: begin
                n_phase = dlcar_pkg::PH_IDLE;
                n_pulse = '0;
                n_half  = '0;
            end
        endcase
    end

    always_comb begin
        start_run  = i_req && !r_active;
        active_eff = r_active || i_req;
        got_eff    = start_run ? 8'd0 : r_got;
        el_eff     = start_run ? 16'd0 : r_el;
        acc        = active_eff && rd_valid && (got_eff < i_cfg.tare_samples)
                     && (el_eff < i_cfg.tare_timeout);
        n_got      = got_eff + {7'd0, acc};
        n_el       = el_eff + {15'd0, active_eff && i_ms && (el_eff != 16'hFFFF)};
        run_end    = active_eff && ((n_got >= i_cfg.tare_samples)
                     || (n_el >= i_cfg.tare_timeout));
        n_active   = active_eff && !run_end;
        run_fail   = run_end && (n_got == 8'd0);
        div_go     = run_end && (n_got != 8'd0);
    end

    assign o_cmd.shift_clr = accept && shift_clr;
    assign o_cmd.shift_en  = accept && shift_en;
    assign o_cmd.held_load = accept && rd_valid;
    assign o_cmd.tare_clr  = accept && start_run;
    assign o_cmd.tare_acc  = accept && acc;
    assign o_div_start     = accept && div_go;
    assign o_div_count     = n_got;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= dlcar_pkg::PH_IDLE;
            r_pulse    <= '0;
            r_half     <= '0;
            r_active   <= 1'b0;
            r_got      <= '0;
            r_el       <= '0;
            r_out_full <= 1'b0;
            r_div_busy <= 1'b0;
            r_f_valid  <= 1'b0;
            r_f_done   <= 1'b0;
            r_f_failed <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_pulse    <= n_pulse;
                r_half     <= n_half;
                r_active   <= n_active;
                r_got      <= n_got;
                r_el       <= n_el;
                r_f_valid  <= rd_valid;
                r_f_done   <= run_end;
                r_f_failed <= run_fail;
                r_out_full <= 1'b1;
            end else if (out_take) begin
                r_out_full <= 1'b0;
            end
            if (accept && div_go) begin
                r_div_busy <= 1'b1;
            end else if (i_div_done) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    assign o_serial_clock  = (r_phase == dlcar_pkg::PH_HIGH);
    assign o_reading_valid = r_f_valid;
    assign o_tare_done     = r_f_done;
    assign o_tare_failed   = r_f_failed;

    a_fail_has_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && o_tare_failed) |-> o_tare_done)
        else $error("Tare failure reported without tare completion.");

    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !o_s_ready)
        else $error("Input ready while the divider is running.");

    a_div_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_start |=> r_div_busy)
        else $error("Divider start did not mark the block busy.");

    a_idle_pulse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dlcar_pkg::PH_IDLE) |-> (r_pulse == '0))
        else $error("Pulse counter not cleared while idle.");

endmodule

/* hdl/dual_load_cell_adc_reader_tare.sv */
// Reader for two serial load-cell converters that share one serial clock pin.
// The slave stream carries one tick transaction per clock cycle of the
// converters' world: both data line levels, a millisecond strobe and a tare
// request. Each accepted tick produces exactly one master stream transaction
// with the serial clock level to drive, the held readings, a reading-complete
// flag and the tare status and values.
// A tick can be accepted every cycle while the output register can take it and
// the divider is idle. A tick that ends a tare run with at least one reading
// starts the bit-serial divider for the averages, and the block then accepts
// nothing until the tare values are loaded and that transaction is released.
// The result of a tick is registered and held until it is taken. The output
// register lets a new tick be accepted in the same cycle the waiting result is
// taken; when the receiver stalls, the input side stalls with it.
// Reset restores the register defaults (half period 100, 10 tare samples,
// timeout 2000 ms), returns the reader to idle with the serial clock low, cancels
// any tare run and clears the held readings and tare values. The user writes
// configuration over the APB port while the stream is idle (not enforced).
module dual_load_cell_adc_reader_tare #(
    parameter int DATA_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // data_line_a, data_line_b, ms_strobe, tare_request, zero fill
    input  logic [dlcar_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // serial_clock, reading_valid, reading_a, reading_b, tare_done,
    // tare_failed, tare_value_a, tare_value_b, zero fill
    output logic [dlcar_pkg::OUT_W-1:0]        m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dlcar_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int SUM_W = DATA_BITS + 8;

    logic [9:0]  r_half_period;
    logic [7:0]  r_tare_samples;
    logic [15:0] r_tare_timeout;
    logic [1:0]  reg_idx;
    logic        cfg_wr;

    dlcar_pkg::t_cfg    cfg;
    dlcar_pkg::t_dp_cmd cmd;

    logic                    serial_clock, reading_valid, tare_done, tare_failed;
    logic                    div_start, div_done;
    logic [7:0]              div_count;
    logic signed [SUM_W-1:0] sum_next_a, sum_next_b, quot_a, quot_b;
    logic signed [23:0]      reading_a, reading_b, tare_value_a, tare_value_b;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period  <= dlcar_pkg::HALF_PERIOD_RST;
            r_tare_samples <= dlcar_pkg::TARE_SAMPLES_RST;
            r_tare_timeout <= dlcar_pkg::TARE_TIMEOUT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                dlcar_pkg::REG_HALF_PERIOD:  r_half_period  <= pwdata[9:0];
                dlcar_pkg::REG_TARE_SAMPLES: r_tare_samples <= pwdata[7:0];
                dlcar_pkg::REG_TARE_TIMEOUT: r_tare_timeout <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dlcar_pkg::REG_HALF_PERIOD:  prdata = {22'd0, r_half_period};
            dlcar_pkg::REG_TARE_SAMPLES: prdata = {24'd0, r_tare_samples};
            dlcar_pkg::REG_TARE_TIMEOUT: prdata = {16'd0, r_tare_timeout};
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg.half_period  = r_half_period;
    assign cfg.tare_samples = r_tare_samples;
    assign cfg.tare_timeout = r_tare_timeout;

    dlcar_ctrl #(
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_s_valid       (s_axis_tvalid),
        .i_data_a        (s_axis_tdata[0]),
        .i_data_b        (s_axis_tdata[1]),
        .i_ms            (s_axis_tdata[2]),
        .i_req           (s_axis_tdata[3]),
        .o_s_ready       (s_axis_tready),
        .i_m_ready       (m_axis_tready),
        .o_m_valid       (m_axis_tvalid),
        .o_serial_clock  (serial_clock),
        .o_reading_valid (reading_valid),
        .o_tare_done     (tare_done),
        .o_tare_failed   (tare_failed),
        .o_cmd           (cmd),
        .o_div_start     (div_start),
        .o_div_count     (div_count),
        .i_div_done      (div_done)
    );

    dlcar_dp #(
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_data_a       (s_axis_tdata[0]),
        .i_data_b       (s_axis_tdata[1]),
        .i_div_done     (div_done),
        .i_quot_a       (quot_a),
        .i_quot_b       (quot_b),
        .o_sum_next_a   (sum_next_a),
        .o_sum_next_b   (sum_next_b),
        .o_reading_a    (reading_a),
        .o_reading_b    (reading_b),
        .o_tare_value_a (tare_value_a),
        .o_tare_value_b (tare_value_b)
    );

    dlcar_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (div_start),
        .i_dividend_a (sum_next_a),
        .i_dividend_b (sum_next_b),
        .i_divisor    (div_count),
        .o_done       (div_done),
        .o_quot_a     (quot_a),
        .o_quot_b     (quot_b)
    );

    assign m_axis_tdata = {4'd0, tare_value_b, tare_value_a, tare_failed, tare_done,
                           reading_b, reading_a, reading_valid, serial_clock};

endmodule
